/* sv/dfs_reachability_matrix_assert.svh */
// Assertion macros shared by the design files.
`ifndef DFS_REACHABILITY_MATRIX_ASSERT_SVH
`define DFS_REACHABILITY_MATRIX_ASSERT_SVH

// Same-cycle implication under reset.
`define DFS_RM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dfs_rm: same-cycle check failed");

// Next-cycle implication under reset.
`define DFS_RM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dfs_rm: next-cycle check failed");

`endif

/* sv/dfs_rm_pkg.sv */
`default_nettype none

package dfs_rm_pkg;

   // Field widths fixed by the item format
   localparam int VERTEX_W = 4;
   localparam int COUNT_W  = 5;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd16;

   typedef enum logic [1:0] {
      OP_ADD_EDGE   = 2'd0,
      OP_FWD_SEARCH = 2'd1,
      OP_REV_SEARCH = 2'd2,
      OP_UNUSED     = 2'd3
   } opcode_type;

   // Decoded class of the request at the input
   typedef enum logic [1:0] {
      KIND_EDGE   = 2'd0,
      KIND_ERROR  = 2'd1,
      KIND_SEARCH = 2'd2,
      KIND_NONE   = 2'd3
   } req_kind_type;

   // Controller to datapath
   typedef struct packed {
      logic add_edge;
      logic emit_error;
      logic start;
      logic step;
      logic push;
      logic pop;
      logic load_top;
      logic emit_last;
   } dfs_rm_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic         req_valid;
      req_kind_type req_kind;
      logic         out_free;
      logic         frame_done;
      logic         hit;
      logic         stack_one;
      logic         stack_empty;
   } dfs_rm_sts_type;

endpackage

`default_nettype wire

/* sv/dfs_rm_req_if.sv */
`default_nettype none

interface dfs_rm_req_if;
   import dfs_rm_pkg::*;

   logic                valid;
   logic                ready;
   opcode_type          opcode;
   logic [VERTEX_W-1:0] first_vertex;
   logic [VERTEX_W-1:0] second_vertex;

   modport source (output valid, output opcode, output first_vertex, output second_vertex,
                   input ready);
   modport sink (input valid, input opcode, input first_vertex, input second_vertex,
                 output ready);
endinterface

`default_nettype wire

/* sv/dfs_rm_rsp_if.sv */
`default_nettype none

interface dfs_rm_rsp_if;
   import dfs_rm_pkg::*;

   logic                valid;
   logic                ready;
   logic [VERTEX_W-1:0] visited_vertex;
   logic                error_flag;
   logic                last_flag;

   modport source (output valid, output visited_vertex, output error_flag, output last_flag,
                   input ready);
   modport sink (input valid, input visited_vertex, input error_flag, input last_flag,
                 output ready);
endinterface

`default_nettype wire

/* sv/dfs_rm_ctrl.sv */
`default_nettype none
`include "dfs_reachability_matrix_assert.svh"

module dfs_rm_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire dfs_rm_pkg::dfs_rm_sts_type sts,
   output dfs_rm_pkg::dfs_rm_cmd_type      cmd,
   output logic                            req_ready
);
   import dfs_rm_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_LOAD   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // Take a request only when idle and the result slot can take a transfer
   assign req_ready = (state_ff == ST_IDLE) && sts.out_free;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_ready && sts.req_valid) begin
               case (sts.req_kind)
                  KIND_EDGE:   cmd.add_edge = 1'b1;
                  KIND_ERROR:  cmd.emit_error = 1'b1;
                  KIND_SEARCH: begin
                     cmd.start = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            if (sts.frame_done) begin
               if (sts.stack_one) begin
                  state_in = ST_FINISH;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = ST_LOAD;
               end
            end else if (sts.hit) begin
               // new vertex: wait for the result slot
               cmd.push = sts.out_free;
            end else begin
               cmd.step = 1'b1;
            end
         end
         ST_LOAD: begin
            cmd.load_top = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit_last = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DFS_RM_ASSERT_IMPL(a_idle_stack_empty, clock, reset, state_ff == ST_IDLE, sts.stack_empty)
   `DFS_RM_ASSERT_NEXT(a_pop_then_load, clock, reset, cmd.pop, state_ff == ST_LOAD)
   `DFS_RM_ASSERT_IMPL(a_finish_at_root, clock, reset, state_ff == ST_FINISH, sts.stack_one)

endmodule

`default_nettype wire

/* sv/dfs_rm_dpath.sv */
`default_nettype none
`include "dfs_reachability_matrix_assert.svh"

module dfs_rm_dpath #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_wr_en,
   input  wire logic [dfs_rm_pkg::COUNT_W-1:0]        csr_wr_data,
   input  wire logic                                  req_valid,
   input  wire dfs_rm_pkg::opcode_type                req_opcode,
   input  wire logic [dfs_rm_pkg::VERTEX_W-1:0]       req_first_vertex,
   input  wire logic [dfs_rm_pkg::VERTEX_W-1:0]       req_second_vertex,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_valid,
   output logic [dfs_rm_pkg::VERTEX_W-1:0]            rsp_visited_vertex,
   output logic                                       rsp_error_flag,
   output logic                                       rsp_last_flag,
   input  wire dfs_rm_pkg::dfs_rm_cmd_type            cmd,
   output dfs_rm_pkg::dfs_rm_sts_type                 sts
);
   import dfs_rm_pkg::*;

   // Vertices addressable: capped by the parameter and by the field width
   localparam int NumV = (MAX_VERTICES < (2 ** VERTEX_W)) ? MAX_VERTICES : (2 ** VERTEX_W);
   localparam int VW   = $clog2(NumV);
   localparam int CW   = $clog2(NumV + 1);

   logic [COUNT_W-1:0] count_ff;
   logic [NumV-1:0]    adj_ff [NumV];
   logic [NumV-1:0]    visited_ff;
   logic [CW-1:0]      sp_ff;
   logic               out_valid_ff;
   logic [VW-1:0]      out_v_ff;
   logic               out_err_ff;
   logic               out_last_ff;
   logic [VW-1:0]      cur_v_ff;
   logic [CW-1:0]      cur_w_ff;
   logic               rev_ff;
   logic [VW-1:0]      pend_ff;
   logic [VW-1:0]      rd_v_ff;
   logic [CW-1:0]      rd_w_ff;

   // Parent frames: vertex and next neighbor to try
   logic [VW-1:0] stk_v_mem [NumV];
   logic [CW-1:0] stk_w_mem [NumV];

   logic [COUNT_W-1:0] count;
   logic               a_bad;
   logic               b_bad;
   logic [VW-1:0]      a_idx;
   logic [VW-1:0]      b_idx;
   logic [VW-1:0]      w_idx;
   logic [CW-1:0]      sp_m1;
   logic [CW-1:0]      sp_m2;
   logic               frame_done;
   logic               edge_bit;
   logic               out_free;
   req_kind_type       req_kind;

   // Vertex count in use
   assign count = (count_ff > COUNT_W'(NumV)) ? COUNT_W'(NumV) : count_ff;

   // Range checks on the request
   assign a_bad = {1'b0, req_first_vertex} >= count;
   assign b_bad = {1'b0, req_second_vertex} >= count;
   assign a_idx = req_first_vertex[VW-1:0];
   assign b_idx = req_second_vertex[VW-1:0];

   always_comb begin
      case (req_opcode)
         OP_ADD_EDGE:   req_kind = (a_bad || b_bad) ? KIND_ERROR : KIND_EDGE;
         OP_FWD_SEARCH: req_kind = a_bad ? KIND_ERROR : KIND_SEARCH;
         OP_REV_SEARCH: req_kind = a_bad ? KIND_ERROR : KIND_SEARCH;
         default:       req_kind = KIND_NONE;
      endcase
   end

   // One neighbor test per cycle while no hit waits for the result slot; reverse reads the column
   assign w_idx      = cur_w_ff[VW-1:0];
   assign frame_done = COUNT_W'(cur_w_ff) >= count;
   assign edge_bit   = rev_ff ? adj_ff[w_idx][cur_v_ff] : adj_ff[cur_v_ff][w_idx];
   assign sp_m1      = sp_ff - CW'(1);
   assign sp_m2      = sp_ff - CW'(2);
   assign out_free   = !out_valid_ff || rsp_ready;

   assign sts.req_valid   = req_valid;
   assign sts.req_kind    = req_kind;
   assign sts.out_free    = out_free;
   assign sts.frame_done  = frame_done;
   assign sts.hit         = !frame_done && edge_bit && !visited_ff[w_idx];
   assign sts.stack_one   = (sp_ff == CW'(1));
   assign sts.stack_empty = (sp_ff == '0);

   // Control state: count register, matrix, marks, stack depth, result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= COUNT_RESET;
         visited_ff   <= '0;
         sp_ff        <= '0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < NumV; i++) begin
            adj_ff[i] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (cmd.add_edge) begin
            adj_ff[a_idx][b_idx] <= 1'b1;
         end
         if (cmd.start) begin
            visited_ff <= NumV'(1) << a_idx;
            sp_ff      <= CW'(1);
         end else if (cmd.push) begin
            visited_ff[w_idx] <= 1'b1;
            sp_ff             <= sp_ff + CW'(1);
         end else if (cmd.pop) begin
            sp_ff <= sp_m1;
         end else if (cmd.emit_last) begin
            sp_ff <= '0;
         end
         if (cmd.emit_error || cmd.push || cmd.emit_last) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Payload: top frame, pending vertex, result fields
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         cur_v_ff <= a_idx;
         cur_w_ff <= '0;
         rev_ff   <= (req_opcode == OP_REV_SEARCH);
         pend_ff  <= a_idx;
      end else if (cmd.push) begin
         cur_v_ff <= w_idx;
         cur_w_ff <= '0;
         pend_ff  <= w_idx;
      end else if (cmd.step) begin
         cur_w_ff <= cur_w_ff + CW'(1);
      end else if (cmd.load_top) begin
         cur_v_ff <= rd_v_ff;
         cur_w_ff <= rd_w_ff;
      end
      if (cmd.emit_error) begin
         out_v_ff    <= '0;
         out_err_ff  <= 1'b1;
         out_last_ff <= 1'b1;
      end else if (cmd.push || cmd.emit_last) begin
         out_v_ff    <= pend_ff;
         out_err_ff  <= 1'b0;
         out_last_ff <= cmd.emit_last;
      end
   end

   // Stack memory: push writes the current frame, pop reads the parent
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stk_v_mem[sp_m1[VW-1:0]] <= cur_v_ff;
         stk_w_mem[sp_m1[VW-1:0]] <= cur_w_ff + CW'(1);
      end
      if (cmd.pop) begin
         rd_v_ff <= stk_v_mem[sp_m2[VW-1:0]];
         rd_w_ff <= stk_w_mem[sp_m2[VW-1:0]];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_visited_vertex = VERTEX_W'(out_v_ff);
   assign rsp_error_flag     = out_err_ff;
   assign rsp_last_flag      = out_last_ff;

   `DFS_RM_ASSERT_IMPL(a_sp_bound, clock, reset, 1'b1, sp_ff <= CW'(NumV))
   `DFS_RM_ASSERT_IMPL(a_emit_needs_slot, clock, reset, cmd.push || cmd.emit_last || cmd.emit_error, out_free)
   `DFS_RM_ASSERT_IMPL(a_error_is_last, clock, reset, out_valid_ff && out_err_ff, out_last_ff)

endmodule

`default_nettype wire

/* sv/dfs_reachability_matrix.sv */
// Channel   Dir  Fields                                         Transfer when
// req_ch    in   opcode, first_vertex, second_vertex            valid && ready
// rsp_ch    out  visited_vertex, error_flag, last_flag          valid && ready
// csr_wr    in   csr_wr_data (vertex count)                     csr_wr_en
//
// Add edge, rejected edge and unused opcode are taken without leaving idle.
// A search tests one neighbor per cycle while the result slot is free; a
// return to the parent passes through a pop and then the load state, as the
// stack read is registered.
// Reset clears the matrix and sets the vertex count to 16; no clearing pass.
// A stalled result slot holds the search at the next vertex found.
`default_nettype none

module dfs_reachability_matrix #(
   parameter int MAX_VERTICES = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   dfs_rm_req_if.sink                          req_ch,
   dfs_rm_rsp_if.source                        rsp_ch,
   input  wire logic                           csr_wr_en,
   input  wire logic [dfs_rm_pkg::COUNT_W-1:0] csr_wr_data
);
   import dfs_rm_pkg::*;

   dfs_rm_cmd_type cmd;
   dfs_rm_sts_type sts;
   logic           req_ready;

   assign req_ch.ready = req_ready;

   // Sequencer
   dfs_rm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .sts       (sts),
      .cmd       (cmd),
      .req_ready (req_ready)
   );

   // Graph storage, search state and result register
   dfs_rm_dpath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_dpath (
      .clock              (clock),
      .reset              (reset),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .req_valid          (req_ch.valid),
      .req_opcode         (req_ch.opcode),
      .req_first_vertex   (req_ch.first_vertex),
      .req_second_vertex  (req_ch.second_vertex),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_visited_vertex (rsp_ch.visited_vertex),
      .rsp_error_flag     (rsp_ch.error_flag),
      .rsp_last_flag      (rsp_ch.last_flag),
      .cmd                (cmd),
      .sts                (sts)
   );

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
   import dfs_rm_pkg::*;

   // Mirror of the graph, the vertex count and the visits still owed
   class visit_tracker;
      typedef struct packed {
         logic [VERTEX_W-1:0] vertex;
         logic                error;
         logic                last;
      } visit_type;

      logic [15:0]        adjacency [16];
      logic [COUNT_W-1:0] count_reg;
      visit_type          expected_visits [$];

      function new();
         foreach (adjacency[i]) adjacency[i] = '0;
         count_reg = COUNT_RESET;
      endfunction

      function void set_vertex_count(logic [COUNT_W-1:0] value);
         count_reg = value;
      endfunction

      // count register capped at the width of the vertex fields
      function int active_vertices();
         return (count_reg > 16) ? 16 : int'(count_reg);
      endfunction

      function int pending();
         return expected_visits.size();
      endfunction

      // Work out every visit an accepted transfer causes
      function void note_request(opcode_type op, logic [VERTEX_W-1:0] a,
                                 logic [VERTEX_W-1:0] b);
         int          limit;
         logic [15:0] seen;
         int          frame_vertex [16];
         int          frame_next [16];
         int          depth;
         int          v;
         int          w;
         bit          found;
         bit          reverse;
         visit_type   item;
         limit = active_vertices();
         case (op)
            OP_ADD_EDGE: begin
               if (a >= limit || b >= limit)
                  expected_visits.push_back('{vertex: '0, error: 1'b1, last: 1'b1});
               else
                  adjacency[a][b] = 1'b1;
            end
            OP_FWD_SEARCH, OP_REV_SEARCH: begin
               if (a >= limit) begin
                  expected_visits.push_back('{vertex: '0, error: 1'b1, last: 1'b1});
               end else begin
                  reverse = (op == OP_REV_SEARCH);
                  seen = '0;
                  seen[a] = 1'b1;
                  expected_visits.push_back('{vertex: a, error: 1'b0, last: 1'b0});
                  frame_vertex[0] = int'(a);
                  frame_next[0] = 0;
                  depth = 1;
                  while (depth > 0) begin
                     v = frame_vertex[depth-1];
                     w = frame_next[depth-1];
                     found = 0;
                     // lowest unvisited neighbor; columns for the transposed graph
                     while (w < limit && !found) begin
                        if ((reverse ? adjacency[w][v] : adjacency[v][w]) && !seen[w])
                           found = 1;
                        else
                           w++;
                     end
                     if (found && depth < 16) begin
                        frame_next[depth-1] = w + 1;
                        seen[w] = 1'b1;
                        expected_visits.push_back('{vertex: w[VERTEX_W-1:0], error: 1'b0,
                                                    last: 1'b0});
                        frame_vertex[depth] = w;
                        frame_next[depth] = 0;
                        depth++;
                     end else begin
                        depth--;
                     end
                  end
                  item = expected_visits.pop_back();
                  item.last = 1'b1;
                  expected_visits.push_back(item);
               end
            end
            default: ;
         endcase
      endfunction

      // Empty string when the result matches the oldest expected visit
      function string check_visit(logic [VERTEX_W-1:0] vertex, logic error, logic last);
         visit_type want;
         string     diffs;
         if (expected_visits.size() == 0)
            return $sformatf("unexpected result: vertex %0d error %0b last %0b",
                             vertex, error, last);
         want = expected_visits.pop_front();
         diffs = "";
         if (vertex !== want.vertex)
            diffs = {diffs, $sformatf(" vertex %0d/%0d", vertex, want.vertex)};
         if (error !== want.error)
            diffs = {diffs, $sformatf(" error %0b/%0b", error, want.error)};
         if (last !== want.last)
            diffs = {diffs, $sformatf(" last %0b/%0b", last, want.last)};
         if (diffs != "")
            return {"result field mismatch (got/want):", diffs};
         return "";
      endfunction
   endclass

   logic               clock;
   logic               reset;
   logic               csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   dfs_rm_req_if req_ch ();
   dfs_rm_rsp_if rsp_ch ();

   dfs_reachability_matrix DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   visit_tracker tracker = new();

   int send_idle_pct;
   int recv_stall_pct;
   int mismatches;
   int requests_sent;
   int searches_sent;
   int results_seen;
   int configs_written;

   // Clock, period 10
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task report_mismatch(input string msg);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, msg);
   endtask

   // Receiver: random stalls on the result channel
   always @(negedge clock) begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Result monitor
   always @(posedge clock) begin
      string msg;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_seen++;
         msg = tracker.check_visit(rsp_ch.visited_vertex, rsp_ch.error_flag,
                                   rsp_ch.last_flag);
         if (msg != "")
            report_mismatch(msg);
      end
   end

   // One request transfer; entered and left at a falling edge
   task send_request(input opcode_type op, input logic [VERTEX_W-1:0] a,
                     input logic [VERTEX_W-1:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.first_vertex <= a;
      req_ch.second_vertex <= b;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_request(op, a, b);
      requests_sent++;
      if (op == OP_FWD_SEARCH || op == OP_REV_SEARCH)
         searches_sent++;
      @(negedge clock);
   endtask

   // Wait until every expected visit is back, then let a trailing edge add settle
   task wait_drained(input int tail);
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (tail) @(negedge clock);
   endtask

   // Register write; only called with the block idle
   task write_vertex_count(input logic [COUNT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      tracker.set_vertex_count(value);
      configs_written++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Watchdog
   initial begin
      #10000000;
      $display("Test completed with failures");
      $finish;
   end

   // Stimulus
   initial begin
      int                  phase_counts [8] = '{4, 16, 2, 9, 1, 31, 6, 16};
      int                  phase;
      int                  live;
      int                  limit;
      int                  pick;
      opcode_type          op;
      logic [VERTEX_W-1:0] a;
      logic [VERTEX_W-1:0] b;

      clock = 1'b0;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_ch.valid = 1'b0;
      req_ch.opcode = OP_ADD_EDGE;
      req_ch.first_vertex = '0;
      req_ch.second_vertex = '0;
      rsp_ch.ready = 1'b0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      mismatches = 0;
      requests_sent = 0;
      searches_sent = 0;
      results_seen = 0;
      configs_written = 0;

      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: reset count of 16, corner vertices, a cycle, a self loop
      send_request(OP_ADD_EDGE, 4'd0, 4'd15);
      send_request(OP_ADD_EDGE, 4'd15, 4'd0);
      send_request(OP_ADD_EDGE, 4'd0, 4'd1);
      send_request(OP_ADD_EDGE, 4'd1, 4'd2);
      send_request(OP_ADD_EDGE, 4'd2, 4'd0);
      send_request(OP_ADD_EDGE, 4'd0, 4'd1);   // duplicate edge
      send_request(OP_ADD_EDGE, 4'd5, 4'd5);   // self loop
      send_request(OP_FWD_SEARCH, 4'd0, 4'd0);
      send_request(OP_REV_SEARCH, 4'd0, 4'd15);
      send_request(OP_FWD_SEARCH, 4'd5, 4'd0);
      send_request(OP_FWD_SEARCH, 4'd10, 4'd3); // isolated vertex
      send_request(OP_UNUSED, 4'd15, 4'd15);    // ignored opcode
      send_request(OP_FWD_SEARCH, 4'd15, 4'd15);
      wait_drained(8);

      // count above 16 is capped
      write_vertex_count(5'd31);
      send_request(OP_ADD_EDGE, 4'd15, 4'd14);
      send_request(OP_REV_SEARCH, 4'd14, 4'd0);
      wait_drained(8);

      // zero count rejects everything
      write_vertex_count(5'd0);
      send_request(OP_ADD_EDGE, 4'd0, 4'd0);
      send_request(OP_FWD_SEARCH, 4'd0, 4'd0);
      send_request(OP_REV_SEARCH, 4'd0, 4'd0);
      wait_drained(8);

      // single vertex
      write_vertex_count(5'd1);
      send_request(OP_FWD_SEARCH, 4'd0, 4'd9);
      send_request(OP_ADD_EDGE, 4'd0, 4'd0);
      send_request(OP_ADD_EDGE, 4'd1, 4'd0);
      send_request(OP_ADD_EDGE, 4'd0, 4'd1);
      send_request(OP_REV_SEARCH, 4'd1, 4'd0);
      send_request(OP_FWD_SEARCH, 4'd0, 4'd0);
      wait_drained(8);

      // Random phases: each its own count and idle pattern
      for (phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
            default: begin send_idle_pct = 30; recv_stall_pct = 30; end
         endcase
         write_vertex_count(phase_counts[phase][COUNT_W-1:0]);
         limit = tracker.active_vertices();
         live = 0;
         while (live < 34) begin
            pick = $urandom_range(0, 99);
            a = VERTEX_W'($urandom_range(0, 15));
            b = VERTEX_W'($urandom_range(0, 15));
            if (pick < 35) begin
               op = OP_ADD_EDGE;
               a = VERTEX_W'($urandom_range(0, limit - 1));
               b = VERTEX_W'($urandom_range(0, limit - 1));
            end else if (pick < 80) begin
               op = $urandom_range(0, 1) ? OP_REV_SEARCH : OP_FWD_SEARCH;
               a = VERTEX_W'($urandom_range(0, limit - 1));
            end else if (pick < 90) begin
               op = OP_ADD_EDGE;
            end else if (pick < 96) begin
               op = $urandom_range(0, 1) ? OP_REV_SEARCH : OP_FWD_SEARCH;
            end else begin
               op = OP_UNUSED;
            end
            send_request(op, a, b);
            if (op != OP_UNUSED)
               live++;
         end
         wait_drained(8);
      end

      // Drain and final verdict
      send_idle_pct = 0;
      recv_stall_pct = 0;
      wait_drained(40);
      if (tracker.pending() != 0)
         report_mismatch($sformatf("%0d expected visits never arrived", tracker.pending()));
      $display("Run: %0d requests (%0d searches), %0d results checked, %0d count writes",
               requests_sent, searches_sent, results_seen, configs_written);
      $display("Covered counts 0, 1, capped 31 and several in between, under four idle mixes");
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

`default_nettype wire
